// File: rtl/ttb_pkg.sv
// Shared constants, field widths and controller/datapath interface types of the text buffer.
`timescale 1ns / 1ps
package ttb_pkg;

	// Grid geometry
	localparam int COLS = 64;
	localparam int ROWS = 32;

	localparam int COL_W     = $clog2(COLS);       // column index of a cell
	localparam int CUR_COL_W = $clog2(COLS + 1);   // cursor column, COLS = wrap pending
	localparam int ROW_W     = $clog2(ROWS);       // row index
	localparam int ADDR_W    = $clog2(ROWS * COLS);

	// Beat field widths
	localparam int ACTION_W      = 2;
	localparam int BYTE_W        = 8;
	localparam int RD_ROW_W      = 5;
	localparam int RD_COL_W      = 6;
	localparam int CELL_W        = 7;
	localparam int CUR_ROW_OUT_W = 5;
	localparam int CUR_COL_OUT_W = 7;
	localparam int S_DATA_W      = 24;
	localparam int S_USER_W      = 2;
	localparam int M_DATA_W      = 24;

	// Action codes
	localparam logic [ACTION_W-1:0] ACT_PUT   = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_READ  = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd2;

	// Byte classes
	localparam logic [BYTE_W-1:0] BYTE_TAB  = 8'd9;
	localparam logic [BYTE_W-1:0] BYTE_LF   = 8'd10;
	localparam logic [BYTE_W-1:0] BYTE_CR   = 8'd13;
	localparam logic [BYTE_W-1:0] PRINT_LO  = 8'd32;
	localparam logic [BYTE_W-1:0] PRINT_HI  = 8'd126;
	localparam logic [BYTE_W-1:0] LEAD2_LO  = 8'hC0;
	localparam logic [BYTE_W-1:0] LEAD2_HI  = 8'hDF;
	localparam logic [BYTE_W-1:0] LEAD3_LO  = 8'hE0;
	localparam logic [BYTE_W-1:0] LEAD3_HI  = 8'hEF;
	localparam logic [BYTE_W-1:0] LEAD4_LO  = 8'hF0;

	localparam logic [1:0] SKIP_LEAD2 = 2'd1;
	localparam logic [1:0] SKIP_LEAD3 = 2'd2;
	localparam logic [1:0] SKIP_LEAD4 = 2'd3;

	localparam int TAB_STEP = 4;   // power of two

	typedef struct packed {
		logic latch;      // capture the input beat
		logic commit;     // apply cursor / pointer / row-valid update
		logic blank_we;   // write a zero into the target row
		logic write_we;   // write the character
		logic read_en;    // read one cell from the grid memory
		logic load_out;   // load the result register
	} ttb_cmd_t;

	typedef struct packed {
		logic need_blank;
		logic need_write;
		logic is_read;
		logic out_free;
		logic blank_last;
	} ttb_sts_t;

endpackage

// File: rtl/ttb_ctrl.sv
// Sequencer of the text buffer: steps one beat through decide, blank, write, read and hold.
`timescale 1ns / 1ps
module ttb_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  ttb_pkg::ttb_sts_t sts,
	output ttb_pkg::ttb_cmd_t cmd
);
	import ttb_pkg::*;

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_DECIDE = 6'b000010,
		ST_BLANK  = 6'b000100,
		ST_WRITE  = 6'b001000,
		ST_READ   = 6'b010000,
		ST_HOLD   = 6'b100000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.latch = 1'b1;
					state_d   = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				cmd.commit = 1'b1;
				if (sts.need_blank) begin
					state_d = ST_BLANK;
				end else if (sts.need_write) begin
					state_d = ST_WRITE;
				end else if (sts.is_read) begin
					cmd.read_en = 1'b1;
					state_d     = ST_READ;
				end else if (sts.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end else begin
					state_d = ST_HOLD;
				end
			end
			ST_BLANK: begin
				cmd.blank_we = 1'b1;
				if (sts.blank_last) begin
					state_d = ST_WRITE;
				end
			end
			ST_WRITE: begin
				cmd.write_we = 1'b1;
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end else begin
					state_d = ST_HOLD;
				end
			end
			ST_READ, ST_HOLD: begin
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end else begin
					state_d = ST_HOLD;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// File: rtl/ttb_datapath.sv
// Datapath of the text buffer: cursor, row ring, grid memory and result register.
`timescale 1ns / 1ps
module ttb_datapath (
	input  logic                               clk,
	input  logic                               arst_n,
	input  ttb_pkg::ttb_cmd_t                  cmd,
	output ttb_pkg::ttb_sts_t                  sts,
	input  logic [ttb_pkg::ACTION_W-1:0]       action,
	input  logic [ttb_pkg::BYTE_W-1:0]         data_byte,
	input  logic [ttb_pkg::RD_ROW_W-1:0]       read_row,
	input  logic [ttb_pkg::RD_COL_W-1:0]       read_col,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [ttb_pkg::CELL_W-1:0]         cell_value,
	output logic [ttb_pkg::CUR_ROW_OUT_W-1:0]  cursor_row,
	output logic [ttb_pkg::CUR_COL_OUT_W-1:0]  cursor_col,
	output logic                               scrolled
);
	import ttb_pkg::*;

	localparam logic [ROW_W:0]     ROWS_X = (ROW_W + 1)'(ROWS);
	localparam logic [CUR_COL_W:0] COLS_X = (CUR_COL_W + 1)'(COLS);
	localparam logic [CUR_COL_W:0] TAB_X  = (CUR_COL_W + 1)'(TAB_STEP);

	// Item captured at accept
	logic [ACTION_W-1:0] action_q;
	logic [BYTE_W-1:0]   byte_q;
	logic [RD_ROW_W-1:0] rrow_q;
	logic [RD_COL_W-1:0] rcol_q;

	// Architectural state
	logic [ROW_W-1:0]     cur_row_q;
	logic [CUR_COL_W-1:0] cur_col_q;
	logic [ROW_W-1:0]     top_q;
	logic [1:0]           skip_q;
	logic [ROWS-1:0]      row_valid_q;

	// Work registers
	logic [ROW_W-1:0]  wr_row_q;
	logic [COL_W-1:0]  wr_col_q;
	logic [CELL_W-1:0] wr_char_q;
	logic [COL_W-1:0]  cnt_q;
	logic              rd_ok_q;
	logic [CELL_W-1:0] rd_data_q;
	logic              scrolled_q;

	// Result register
	logic                 out_valid_q;
	logic [CELL_W-1:0]    out_cell_q;
	logic [ROW_W-1:0]     out_row_q;
	logic [CUR_COL_W-1:0] out_col_q;
	logic                 out_scr_q;

	logic [CELL_W-1:0] cell_mem_q [ROWS * COLS];

	function automatic logic [ROW_W-1:0] phys_row(input logic [ROW_W-1:0] base,
	                                              input logic [ROW_W-1:0] ofs);
		logic [ROW_W:0] s;
		s = {1'b0, base} + {1'b0, ofs};
		if (s >= ROWS_X) begin
			s = s - ROWS_X;
		end
		return s[ROW_W-1:0];
	endfunction

	// Next state for the current item
	logic [ROW_W-1:0]     nx_row;
	logic [CUR_COL_W-1:0] nx_col;
	logic [ROW_W-1:0]     nx_top;
	logic [1:0]           nx_skip;
	logic [ROWS-1:0]      nx_valid;
	logic                 nx_scr;
	logic                 nx_write;
	logic [COL_W-1:0]     nx_wcol;
	logic [ROW_W-1:0]     nx_wrow;

	always_comb begin
		logic [ROW_W:0]     r;
		logic [CUR_COL_W:0] c;
		logic [CUR_COL_W:0] t;
		logic               scr;
		logic               wr;
		logic [COL_W-1:0]   wcol;
		logic [ROW_W-1:0]   top_n;
		logic [ROWS-1:0]    val_n;
		logic [1:0]         skip_n;

		r      = {1'b0, cur_row_q};
		c      = {1'b0, cur_col_q};
		t      = '0;
		scr    = 1'b0;
		wr     = 1'b0;
		wcol   = '0;
		top_n  = top_q;
		val_n  = row_valid_q;
		skip_n = skip_q;

		if (skip_q != 2'd0) begin
			skip_n = skip_q - 2'd1;
		end else if (byte_q >= LEAD3_LO && byte_q <= LEAD3_HI) begin
			skip_n = SKIP_LEAD3;
		end else if (byte_q >= LEAD2_LO && byte_q <= LEAD2_HI) begin
			skip_n = SKIP_LEAD2;
		end else if (byte_q >= LEAD4_LO) begin
			skip_n = SKIP_LEAD4;
		end else if (byte_q == BYTE_LF || byte_q == BYTE_CR) begin
			c = '0;
			r = r + 1'b1;
		end else if (byte_q == BYTE_TAB) begin
			t = (c + TAB_X) & ~(TAB_X - 1'b1);
			if (t >= COLS_X) begin
				c = '0;
				r = r + 1'b1;
			end else begin
				c = t;
			end
		end else if (byte_q >= PRINT_LO && byte_q <= PRINT_HI) begin
			if (c >= COLS_X) begin
				c = '0;
				r = r + 1'b1;
			end
			if (r >= ROWS_X) begin
				scr = 1'b1;
				r   = ROWS_X - 1'b1;
			end
			wcol = c[COL_W-1:0];
			wr   = 1'b1;
			c    = c + 1'b1;
		end
		if (r >= ROWS_X) begin
			scr = 1'b1;
			r   = ROWS_X - 1'b1;
		end

		// Scroll: advance the ring pointer, the old top row becomes the blank last row
		if (scr) begin
			top_n        = (top_q == ROW_W'(ROWS - 1)) ? '0 : top_q + 1'b1;
			val_n[top_q] = 1'b0;
		end

		nx_row   = r[ROW_W-1:0];
		nx_col   = c[CUR_COL_W-1:0];
		nx_top   = top_n;
		nx_skip  = skip_n;
		nx_valid = val_n;
		nx_scr   = scr;
		nx_write = wr;
		nx_wcol  = wcol;
		nx_wrow  = phys_row(top_n, nx_row);
	end

	logic is_put;
	logic is_clear;
	logic rd_in_range;
	logic [ROW_W-1:0]  rd_row;
	logic [ADDR_W-1:0] rd_addr;
	logic [ADDR_W-1:0] mem_addr;
	logic              mem_we;
	logic [CELL_W-1:0] mem_wdata;

	assign is_put      = (action_q == ACT_PUT);
	assign is_clear    = (action_q == ACT_CLEAR);
	assign rd_in_range = (int'(rrow_q) < ROWS) && (int'(rcol_q) < COLS);
	assign rd_row      = phys_row(top_q, ROW_W'(rrow_q));
	assign rd_addr     = ADDR_W'(rd_row) * ADDR_W'(COLS) + ADDR_W'(rcol_q);

	assign mem_we    = cmd.blank_we | cmd.write_we;
	assign mem_wdata = cmd.write_we ? wr_char_q : '0;
	assign mem_addr  = ADDR_W'(wr_row_q) * ADDR_W'(COLS)
	                 + ADDR_W'(cmd.blank_we ? cnt_q : wr_col_q);

	assign sts.need_write = is_put && nx_write;
	assign sts.need_blank = is_put && nx_write && !nx_valid[nx_wrow];
	assign sts.is_read    = (action_q == ACT_READ);
	assign sts.out_free   = !out_valid_q || out_ready;
	assign sts.blank_last = (cnt_q == COL_W'(COLS - 1));

	// Result of the beat, taken from next-state values while the update commits
	logic [ROW_W-1:0]     res_row;
	logic [CUR_COL_W-1:0] res_col;
	logic                 res_scr;

	always_comb begin
		res_row = cur_row_q;
		res_col = cur_col_q;
		res_scr = scrolled_q;
		if (cmd.commit) begin
			if (is_put) begin
				res_row = nx_row;
				res_col = nx_col;
				res_scr = nx_scr;
			end else if (is_clear) begin
				res_row = '0;
				res_col = '0;
				res_scr = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_row_q   <= '0;
			cur_col_q   <= '0;
			top_q       <= '0;
			skip_q      <= '0;
			row_valid_q <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.latch) begin
				cnt_q <= '0;
			end else if (cmd.blank_we) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (cmd.commit) begin
				case (action_q)
					ACT_PUT: begin
						cur_row_q   <= nx_row;
						cur_col_q   <= nx_col;
						top_q       <= nx_top;
						skip_q      <= nx_skip;
						row_valid_q <= nx_valid;
					end
					ACT_CLEAR: begin
						cur_row_q   <= '0;
						cur_col_q   <= '0;
						top_q       <= '0;
						skip_q      <= '0;
						row_valid_q <= '0;
					end
					default: begin
					end
				endcase
			end
			if (cmd.blank_we && sts.blank_last) begin
				row_valid_q[wr_row_q] <= 1'b1;
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			action_q   <= action;
			byte_q     <= data_byte;
			rrow_q     <= read_row;
			rcol_q     <= read_col;
			rd_ok_q    <= 1'b0;
			scrolled_q <= 1'b0;
		end
		if (cmd.commit) begin
			scrolled_q <= is_put && nx_scr;
			wr_row_q   <= nx_wrow;
			wr_col_q   <= nx_wcol;
			wr_char_q  <= byte_q[CELL_W-1:0];
		end
		if (cmd.read_en) begin
			rd_ok_q <= rd_in_range && row_valid_q[rd_row];
		end
		if (cmd.load_out) begin
			out_cell_q <= rd_ok_q ? rd_data_q : '0;
			out_row_q  <= res_row;
			out_col_q  <= res_col;
			out_scr_q  <= res_scr;
		end
	end

	// Grid memory, one port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			cell_mem_q[mem_addr] <= mem_wdata;
		end
		if (cmd.read_en && rd_in_range) begin
			rd_data_q <= cell_mem_q[rd_addr];
		end
	end

	assign out_valid  = out_valid_q;
	assign cell_value = out_cell_q;
	assign cursor_row = CUR_ROW_OUT_W'(out_row_q);
	assign cursor_col = CUR_COL_OUT_W'(out_col_q);
	assign scrolled   = out_scr_q;

	a_scroll_row: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit && is_put && nx_scr) |=> (cur_row_q == ROW_W'(ROWS - 1)))
		else $error("scroll did not park the cursor on the last row");

	a_blank_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.blank_we && sts.blank_last) |=> row_valid_q[wr_row_q])
		else $error("row not marked valid after blanking");

	a_write_on_valid_row: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.write_we |-> row_valid_q[wr_row_q])
		else $error("character written into a row that was never blanked");

	a_single_port: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_we && cmd.read_en))
		else $error("grid memory read and written in the same cycle");

	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, cur_col_q} <= COLS_X)
		else $error("cursor column beyond the wrap position");

endmodule

// File: rtl/text_terminal_buffer_top.sv
// Top level of the scrolling text terminal buffer: stream ports, sequencer and datapath.
`timescale 1ns / 1ps
// Usage:
// Input beats on s_* carry an action in s_tuser: put byte, read cell or clear grid.
// Every accepted beat yields exactly one result beat on m_*, in order, carrying the
// cell read (0 for non-read actions or empty cells), the cursor after the item and
// a flag that the grid scrolled.
// A put that writes nothing and a clear load the result in the decide state; a read
// loads it from the read state, a printable byte from the write state.
// A printable byte that lands on a row not yet written since reset, clear or scroll
// first blanks that row through the single grid memory port, one cell per cycle.
// The sequencer takes one item at a time; s_tready is high only between items.
// A result waits in an output register when m_tready is low; the block finishes the
// next item and then holds it until that register is taken.
// Reset (arst_n low) empties the grid through row valid bits, so no sweep is needed
// and the block accepts beats as soon as reset is released.
module text_terminal_buffer_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [ttb_pkg::S_DATA_W-1:0]    s_tdata,   // data_byte, read_row, read_col
	input  logic [ttb_pkg::S_USER_W-1:0]    s_tuser,   // action
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [ttb_pkg::M_DATA_W-1:0]    m_tdata    // cell_value, cursor_row, cursor_col, scrolled
);
	import ttb_pkg::*;

	localparam int RROW_LO = BYTE_W;
	localparam int RCOL_LO = BYTE_W + RD_ROW_W;
	localparam int OROW_LO = CELL_W;
	localparam int OCOL_LO = CELL_W + CUR_ROW_OUT_W;
	localparam int OSCR    = CELL_W + CUR_ROW_OUT_W + CUR_COL_OUT_W;

	ttb_cmd_t cmd;
	ttb_sts_t sts;

	logic [CELL_W-1:0]        cell_value;
	logic [CUR_ROW_OUT_W-1:0] cursor_row;
	logic [CUR_COL_OUT_W-1:0] cursor_col;
	logic                     scrolled;

	ttb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	ttb_datapath u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.action     (s_tuser[ACTION_W-1:0]),
		.data_byte  (s_tdata[BYTE_W-1:0]),
		.read_row   (s_tdata[RROW_LO +: RD_ROW_W]),
		.read_col   (s_tdata[RCOL_LO +: RD_COL_W]),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.cell_value (cell_value),
		.cursor_row (cursor_row),
		.cursor_col (cursor_col),
		.scrolled   (scrolled)
	);

	always_comb begin
		m_tdata                          = '0;
		m_tdata[CELL_W-1:0]              = cell_value;
		m_tdata[OROW_LO +: CUR_ROW_OUT_W] = cursor_row;
		m_tdata[OCOL_LO +: CUR_COL_OUT_W] = cursor_col;
		m_tdata[OSCR]                    = scrolled;
	end

endmodule
